FILE: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared codes, field widths and the controller-to-datapath command type for
// the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEQ_DEPTH = 256;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 9;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

	typedef struct packed {
		logic capture;
		logic exec;
	} deq_cmd_t;

endpackage

FILE: hw/rtl/deque_with_indexed_peek.sv
// ----------------------------------------------------------------------------
// deque_with_indexed_peek
// Double-ended queue of signed 32-bit values with indexed reads from either end.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operation, push_value and position and raise start. The request is
//   taken at a rising edge where start is high and busy is low.
//   Operations push or pop at either end, or read the n-th element from the
//   front or the back; position 0 and 1 both name the end element.
//   Each request gives one result: status, read_value and occupancy are valid
//   while done is high, for exactly one cycle, after the sequencer has passed
//   through its execute and response states. busy stays high in both states,
//   so a new request is taken only once the last result has been presented;
//   the sequencer spends the execute state on the single access to the ring
//   store and the response state on its registered read data.
//   The receiver cannot stall; a result not taken while done is high is lost.
//   Reset empties the queue at once (pointers and count cleared); the store
//   itself is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module deque_with_indexed_peek
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OP_W-1:0]            operation,
	input  logic signed [VALUE_W-1:0]  push_value,
	input  logic [POS_W-1:0]           position,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [VALUE_W-1:0]  read_value,
	output logic [OCC_W-1:0]           occupancy
);

	deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	deq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.operation  (operation),
		.push_value (push_value),
		.position   (position),
		.status     (status),
		.read_value (read_value),
		.occupancy  (occupancy)
	);

endmodule

FILE: hw/rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for one request: capture, execute against the ring store, and
// present the result for a single cycle.
// ----------------------------------------------------------------------------
module deq_ctrl
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output deq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_n = S_EXEC;
			end
			S_EXEC: state_n = S_RESP;
			S_RESP: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_RESP);
	assign cmd.capture = start && !busy;
	assign cmd.exec    = (state_q == S_EXEC);

`ifndef SYNTHESIS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.exec)
		else $error("accepted transfer did not move to execution");
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done && busy)
		else $error("execution was not followed by a result");
`endif

endmodule

FILE: hw/rtl/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Request registers, ring store, front and back pointers, element count and
// result registers of the double-ended queue.
// ----------------------------------------------------------------------------
module deq_dp
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  deq_cmd_t                   cmd,
	input  logic [OP_W-1:0]            operation,
	input  logic signed [VALUE_W-1:0]  push_value,
	input  logic [POS_W-1:0]           position,
	output logic [STATUS_W-1:0]        status,
	output logic signed [VALUE_W-1:0]  read_value,
	output logic [OCC_W-1:0]           occupancy
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam int SW = ((IW > POS_W) ? IW : POS_W) + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	logic [OP_W-1:0]    op_q;
	logic [VALUE_W-1:0] val_q;
	logic [POS_W-1:0]   pos_q;

	logic [IW-1:0] front_q, back_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] front_n, back_n;
	logic [CW-1:0] count_n;

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rdata_q;
	logic [IW-1:0]      addr;
	logic               we, re;

	logic [STATUS_W-1:0] stat_n, status_q;
	logic                rd_n, rd_q;

	logic [POS_W-1:0] pos_eff;
	logic [SW-1:0]    sum_front, sum_back, sum_sel;
	logic [IW-1:0]    read_idx;
	logic             out_of_range;
	logic             is_empty, is_full;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			val_q <= push_value;
			pos_q <= position;
		end
	end

	assign pos_eff      = (pos_q == '0) ? POS_W'(1) : pos_q;
	assign out_of_range = PW'(pos_eff) > PW'(count_q);
	assign is_empty     = (count_q == '0);
	assign is_full      = (count_q == FULL_CNT);

	// A valid position keeps both sums below twice the depth, so one
	// conditional subtract wraps them into the ring.
	assign sum_front = SW'(front_q) + SW'(pos_eff - 1'b1);
	assign sum_back  = SW'(back_q) + DEPTH_S - SW'(pos_eff);
	assign sum_sel   = (op_q == OP_READ_FRONT) ? sum_front : sum_back;
	assign read_idx  = (sum_sel >= DEPTH_S) ? IW'(sum_sel - DEPTH_S) : IW'(sum_sel);

	always_comb begin
		front_n = front_q;
		back_n  = back_q;
		count_n = count_q;
		addr    = front_q;
		we      = 1'b0;
		re      = 1'b0;
		stat_n  = STAT_OK;
		rd_n    = 1'b0;
		case (op_q)
			OP_PUSH_FRONT: begin
				if (is_full) begin
					stat_n = STAT_FULL;
				end else begin
					front_n = ring_prev(front_q);
					addr    = front_n;
					we      = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (is_full) begin
					stat_n = STAT_FULL;
				end else begin
					addr    = back_q;
					back_n  = ring_next(back_q);
					we      = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (is_empty) begin
					stat_n = STAT_EMPTY;
				end else begin
					addr    = front_q;
					front_n = ring_next(front_q);
					re      = 1'b1;
					rd_n    = 1'b1;
					count_n = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					stat_n = STAT_EMPTY;
				end else begin
					back_n  = ring_prev(back_q);
					addr    = back_n;
					re      = 1'b1;
					rd_n    = 1'b1;
					count_n = count_q - 1'b1;
				end
			end
			OP_READ_FRONT, OP_READ_BACK: begin
				if (out_of_range) begin
					stat_n = STAT_RANGE;
				end else begin
					addr = read_idx;
					re   = 1'b1;
					rd_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && we) mem_q[addr] <= val_q;
		if (cmd.exec && re) rdata_q <= mem_q[addr];
		if (cmd.exec) status_q <= stat_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			rd_q    <= 1'b0;
		end else if (cmd.exec) begin
			front_q <= front_n;
			back_q  <= back_n;
			count_q <= count_n;
			rd_q    <= rd_n;
		end
	end

	assign status     = status_q;
	assign read_value = rd_q ? rdata_q : '0;
	assign occupancy  = OCC_W'(count_q);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("element count exceeds the store depth");
	a_ends_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(is_empty || is_full) |-> (front_q == back_q))
		else $error("front and back pointers disagree with the count");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && we) |=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted push did not add one element");
`endif

endmodule
